@@ rtl/rac_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rac_pkg
// Shared widths, status codes and controller/datapath command types.
// ---------------------------------------------------------------------------
package rac_pkg;

   localparam int OPERAND_W  = 32;  // request numerator/denominator
   localparam int RES_NUM_W  = 32;
   localparam int RES_DEN_W  = 31;
   localparam int STATUS_W   = 2;
   localparam int PROD_W     = 64;  // 32x32 product, magnitudes
   localparam int ACC_W      = 65;  // signed sum of two products
   localparam int SHIFT_W    = 6;   // common power of two in the gcd
   localparam int DIV_CNT_W  = 6;   // one quotient bit per step
   localparam int DIV_STEPS  = 64;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_DEN = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

   typedef enum logic [1:0] {
      MUL_AD,   // |a| * |d|
      MUL_CB,   // |c| * b
      MUL_BD    // b * |d|
   } mul_sel_type;

   typedef enum logic [1:0] {
      OUT_ZERO_DEN,
      OUT_ZERO_SUM,
      OUT_REDUCED
   } out_kind_type;

   typedef struct packed {
      logic         capture;
      logic         mul_en;
      mul_sel_type  mul_sel;
      logic         acc_load;
      logic         acc_add;
      logic         dn_load;
      logic         gcd_init;
      logic         gcd_step;
      logic         div_init;
      logic         div_step;
      logic         out_load;
      out_kind_type out_kind;
   } cmd_type;

   typedef struct packed {
      logic den_zero;
      logic acc_zero;
      logic gcd_done;
   } sts_type;

endpackage

@@ rtl/rac_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rac_if
// Request and response channels, valid/ready with flat payload fields.
// ---------------------------------------------------------------------------
interface rac_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  cmd;
   logic signed [rac_pkg::OPERAND_W-1:0]  operand_num;
   logic signed [rac_pkg::OPERAND_W-1:0]  operand_den;

   modport source (output valid, output cmd, output operand_num, output operand_den,
                   input ready);
   modport sink   (input valid, input cmd, input operand_num, input operand_den,
                   output ready);
endinterface

interface rac_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [rac_pkg::RES_NUM_W-1:0]  result_num;
   logic        [rac_pkg::RES_DEN_W-1:0]  result_den;
   logic        [rac_pkg::STATUS_W-1:0]   status;

   modport source (output valid, output result_num, output result_den, output status,
                   input ready);
   modport sink   (input valid, input result_num, input result_den, input status,
                   output ready);
endinterface

@@ rtl/rational_accumulator_normalize_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rational_accumulator_normalize_top
// Running reduced fraction: load or add a signed fraction per request.
// ---------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  req_chan  in   valid/ready    cmd, operand_num[31:0], operand_den[31:0]
//  rsp_chan  out  valid/ready    result_num[31:0], result_den[30:0], status[1:0]
//
//  Flow: one request at a time. A zero denominator skips the multiplies, and a
//    zero sum skips the gcd and divide. Otherwise the binary gcd loop runs,
//    one compare/subtract or halving of 64-bit values a cycle, then the
//    restoring divide, one quotient bit a cycle.
//  Reset: synchronous; stored fraction returns to 0/1, no clearing pass.
//  Stalls: a new request is taken while the previous result waits in the
//    output register; a finished result waits in the sequencer until then.
// ---------------------------------------------------------------------------
module rational_accumulator_normalize_top #(
   parameter int VALUE_WIDTH = 32   // stored fraction width, 8..32
) (
   input  logic       clock,
   input  logic       reset,
   rac_req_if.sink    req_chan,
   rac_rsp_if.source  rsp_chan
);

   rac_pkg::cmd_type cmd;
   rac_pkg::sts_type sts;
   logic             req_ready;
   logic             rsp_valid;

   // sequencer: multiply steps, gcd loop, divide count, result launch
   rac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // arithmetic and the stored fraction; result payload registered here
   rac_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_cmd         (req_chan.cmd),
      .req_operand_num (req_chan.operand_num),
      .req_operand_den (req_chan.operand_den),
      .rsp_result_num  (rsp_chan.result_num),
      .rsp_result_den  (rsp_chan.result_den),
      .rsp_status      (rsp_chan.status)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

endmodule

@@ rtl/rac_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rac_ctrl
// Sequencer: multiply steps, binary gcd loop, divide loop, result launch.
// ---------------------------------------------------------------------------
module rac_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  rac_pkg::sts_type sts,
   output rac_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_A,
      S_MUL_B,
      S_MUL_C,
      S_MUL_D,
      S_PREP,
      S_GCD,
      S_DIV,
      S_FINISH
   } state_type;

   localparam logic [rac_pkg::DIV_CNT_W-1:0] CNT_LAST =
      rac_pkg::DIV_CNT_W'(rac_pkg::DIV_STEPS - 1);

   state_type                         state_ff, state_in;
   rac_pkg::out_kind_type             kind_ff, kind_in;
   logic [rac_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      cmd.out_kind = kind_ff;
      state_in     = state_ff;
      kind_in      = kind_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_MUL_A;
            end
         end
         S_MUL_A: begin
            if (sts.den_zero) begin
               kind_in  = rac_pkg::OUT_ZERO_DEN;
               state_in = S_FINISH;
            end else begin
               cmd.mul_en  = 1'b1;
               cmd.mul_sel = rac_pkg::MUL_AD;
               state_in    = S_MUL_B;
            end
         end
         S_MUL_B: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = rac_pkg::MUL_CB;
            cmd.acc_load = 1'b1;
            state_in     = S_MUL_C;
         end
         S_MUL_C: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = rac_pkg::MUL_BD;
            cmd.acc_add = 1'b1;
            state_in    = S_MUL_D;
         end
         S_MUL_D: begin
            cmd.dn_load = 1'b1;
            state_in    = S_PREP;
         end
         S_PREP: begin
            if (sts.acc_zero) begin
               kind_in  = rac_pkg::OUT_ZERO_SUM;
               state_in = S_FINISH;
            end else begin
               cmd.gcd_init = 1'b1;
               state_in     = S_GCD;
            end
         end
         S_GCD: begin
            if (sts.gcd_done) begin
               cmd.div_init = 1'b1;
               cnt_in       = '0;
               state_in     = S_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               kind_in  = rac_pkg::OUT_REDUCED;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         kind_ff      <= rac_pkg::OUT_ZERO_DEN;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(cmd.out_load && rsp_valid_ff && !rsp_ready))
      else $error("result register overwritten while stalled");

   a_valid_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("response raised outside finish");

   a_launch_returns_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("launch did not return to idle with valid set");

endmodule

@@ rtl/rac_datapath.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rac_datapath
// Cross-multiply, binary gcd, two-lane restoring divide, running fraction.
// ---------------------------------------------------------------------------
module rac_datapath #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rac_pkg::cmd_type                      cmd,
   output rac_pkg::sts_type                      sts,
   input  logic                                  req_cmd,
   input  logic signed [rac_pkg::OPERAND_W-1:0]  req_operand_num,
   input  logic signed [rac_pkg::OPERAND_W-1:0]  req_operand_den,
   output logic signed [rac_pkg::RES_NUM_W-1:0]  rsp_result_num,
   output logic        [rac_pkg::RES_DEN_W-1:0]  rsp_result_den,
   output logic        [rac_pkg::STATUS_W-1:0]   rsp_status
);

   localparam int DEN_W = VALUE_WIDTH - 1;
   localparam int OW    = rac_pkg::OPERAND_W;
   localparam int PW    = rac_pkg::PROD_W;
   localparam logic [PW-1:0] HALF = PW'(1) << (VALUE_WIDTH - 1);

   typedef struct packed {
      logic [PW-1:0] rem;
      logic [PW-1:0] quo;
   } div_lane_type;

   function automatic div_lane_type div_lane(input div_lane_type cur,
                                             input logic [PW-1:0] dvsr);
      logic [PW:0]  trial;
      logic         qbit;
      div_lane_type nxt;
      trial = {cur.rem, cur.quo[PW-1]};
      qbit  = (trial >= {1'b0, dvsr});
      nxt.rem = qbit ? PW'(trial - {1'b0, dvsr}) : trial[PW-1:0];
      nxt.quo = {cur.quo[PW-2:0], qbit};
      return nxt;
   endfunction

   // running fraction
   logic signed [VALUE_WIDTH-1:0]   sum_num_ff;
   logic        [DEN_W-1:0]         sum_den_ff;

   // latched request
   logic                            cmd_bit_ff;
   logic        [OW-1:0]            c_ff, d_ff;

   // products
   logic        [PW-1:0]            prod_ff, prod_in;
   logic signed [rac_pkg::ACC_W-1:0] acc_ff, prod_ext;
   logic        [PW-1:0]            dn_ff;

   // gcd and divide
   logic        [PW-1:0]            x_ff, x_in, y_ff, y_in, diff;
   logic        [rac_pkg::SHIFT_W-1:0] k_ff, k_in;
   logic        [PW-1:0]            mag_ff, dmag_ff, g_ff, acc_mag;
   logic                            neg_ff, x_gt;
   div_lane_type                    lane_m_ff, lane_d_ff;

   // operand magnitudes
   logic signed [VALUE_WIDTH:0]     sum_num_ext, sum_num_neg;
   logic        [OW-1:0]            a_mag, b_val, c_mag, d_mag, mul_x, mul_y;
   logic                            sa, sc;

   // result selection
   logic                            ovf;
   logic signed [VALUE_WIDTH-1:0]   new_num;
   logic        [DEN_W-1:0]         new_den;

   assign sum_num_ext = (VALUE_WIDTH + 1)'(sum_num_ff);
   assign sum_num_neg = -sum_num_ext;
   assign sa    = cmd_bit_ff & sum_num_ff[VALUE_WIDTH-1];
   assign a_mag = !cmd_bit_ff ? '0 :
                  sum_num_ff[VALUE_WIDTH-1] ? OW'(sum_num_neg) : OW'(sum_num_ext);
   assign b_val = cmd_bit_ff ? OW'(sum_den_ff) : OW'(1);
   assign c_mag = c_ff[OW-1] ? (~c_ff + OW'(1)) : c_ff;
   assign d_mag = d_ff[OW-1] ? (~d_ff + OW'(1)) : d_ff;
   assign sc    = c_ff[OW-1] ^ d_ff[OW-1];  // sign of c after moving d's sign

   always_comb begin
      case (cmd.mul_sel)
         rac_pkg::MUL_AD: begin mul_x = a_mag; mul_y = d_mag; end
         rac_pkg::MUL_CB: begin mul_x = c_mag; mul_y = b_val; end
         rac_pkg::MUL_BD: begin mul_x = b_val; mul_y = d_mag; end
         default:         begin mul_x = '0;    mul_y = '0;    end
      endcase
      prod_in = mul_x * mul_y;
   end

   assign prod_ext = $signed({1'b0, prod_ff});
   assign acc_mag  = acc_ff[rac_pkg::ACC_W-1] ? PW'(-acc_ff) : acc_ff[PW-1:0];

   // binary gcd: strip common twos, then odd x against y, halving the difference
   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      k_in = k_ff;
      x_gt = (x_ff > y_ff);
      diff = x_gt ? (x_ff - y_ff) : (y_ff - x_ff);
      if (!x_ff[0] && !y_ff[0]) begin
         x_in = x_ff >> 1;
         y_in = y_ff >> 1;
         k_in = k_ff + 1'b1;
      end else if (!x_ff[0]) begin
         x_in = x_ff >> 1;
      end else if (!y_ff[0]) begin
         y_in = y_ff >> 1;
      end else begin
         if (x_gt) begin
            x_in = y_ff;
         end
         y_in = diff >> 1;
      end
   end

   assign sts.den_zero = (d_ff == '0);
   assign sts.acc_zero = (acc_ff == '0);
   assign sts.gcd_done = x_ff[0] && (y_ff == '0);

   assign ovf = (lane_d_ff.quo > HALF - 1'b1) ||
                (neg_ff ? (lane_m_ff.quo > HALF) : (lane_m_ff.quo > HALF - 1'b1));
   assign new_num = neg_ff ? VALUE_WIDTH'(-lane_m_ff.quo) : VALUE_WIDTH'(lane_m_ff.quo);
   assign new_den = DEN_W'(lane_d_ff.quo);

   // payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_bit_ff <= req_cmd;
         c_ff       <= req_operand_num;
         d_ff       <= req_operand_den;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.acc_load) begin
         acc_ff <= sa ? -prod_ext : prod_ext;
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + (sc ? -prod_ext : prod_ext);
      end
      if (cmd.dn_load) begin
         dn_ff <= prod_ff;
      end
      if (cmd.gcd_init) begin
         x_ff    <= acc_mag;
         y_ff    <= dn_ff;
         k_ff    <= '0;
         mag_ff  <= acc_mag;
         dmag_ff <= dn_ff;
         neg_ff  <= acc_ff[rac_pkg::ACC_W-1];
      end else if (cmd.gcd_step) begin
         x_ff <= x_in;
         y_ff <= y_in;
         k_ff <= k_in;
      end
      if (cmd.div_init) begin
         g_ff          <= x_ff << k_ff;
         lane_m_ff.rem <= '0;
         lane_m_ff.quo <= mag_ff;
         lane_d_ff.rem <= '0;
         lane_d_ff.quo <= dmag_ff;
      end else if (cmd.div_step) begin
         lane_m_ff <= div_lane(lane_m_ff, g_ff);
         lane_d_ff <= div_lane(lane_d_ff, g_ff);
      end
   end

   // running fraction and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_num_ff <= '0;
         sum_den_ff <= DEN_W'(1);
      end else if (cmd.out_load) begin
         case (cmd.out_kind)
            rac_pkg::OUT_ZERO_SUM: begin
               sum_num_ff <= '0;
               sum_den_ff <= DEN_W'(1);
            end
            rac_pkg::OUT_REDUCED: begin
               if (!ovf) begin
                  sum_num_ff <= new_num;
                  sum_den_ff <= new_den;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         case (cmd.out_kind)
            rac_pkg::OUT_ZERO_SUM: begin
               rsp_result_num <= '0;
               rsp_result_den <= rac_pkg::RES_DEN_W'(1);
               rsp_status     <= rac_pkg::STATUS_OK;
            end
            rac_pkg::OUT_REDUCED: begin
               if (ovf) begin
                  rsp_result_num <= rac_pkg::RES_NUM_W'(sum_num_ff);
                  rsp_result_den <= rac_pkg::RES_DEN_W'(sum_den_ff);
                  rsp_status     <= rac_pkg::STATUS_OVERFLOW;
               end else begin
                  rsp_result_num <= rac_pkg::RES_NUM_W'(new_num);
                  rsp_result_den <= rac_pkg::RES_DEN_W'(new_den);
                  rsp_status     <= rac_pkg::STATUS_OK;
               end
            end
            default: begin
               rsp_result_num <= rac_pkg::RES_NUM_W'(sum_num_ff);
               rsp_result_den <= rac_pkg::RES_DEN_W'(sum_den_ff);
               rsp_status     <= rac_pkg::STATUS_ZERO_DEN;
            end
         endcase
      end
   end

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      sum_den_ff != '0)
      else $error("stored denominator is zero");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> g_ff != '0)
      else $error("divide step with zero gcd");

   a_exact_divide: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && cmd.out_kind == rac_pkg::OUT_REDUCED)
         |-> (lane_m_ff.rem == '0 && lane_d_ff.rem == '0))
      else $error("gcd does not divide numerator and denominator");

endmodule

@@ tb/rational_accumulator_normalize_top_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rational_accumulator_normalize_top_tb
// Self-checking bench for the running reduced fraction. Load and add
// requests, directed corner cases then random traffic, are driven over the
// valid/ready request channel. A local fraction model predicts every
// response, and the monitor compares each response field by field, in order.
// ---------------------------------------------------------------------------
module rational_accumulator_normalize_top_tb;

   localparam int VALUE_WIDTH = 32;

   // request opcodes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_ADD  = 1'b1;

   localparam logic signed [rac_pkg::OPERAND_W-1:0] OPND_MIN = 32'sh8000_0000;
   localparam logic signed [rac_pkg::OPERAND_W-1:0] OPND_MAX = 32'sh7FFF_FFFF;

   localparam int RANDOM_REQS    = 1100;
   localparam int MAX_IDLE       = 14;
   localparam int HOLD_AFTER     = 400;   // requests taken before the long hold
   localparam int HOLD_CYCLES    = 400;
   localparam int TAIL_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_LIMIT   = 10;

   typedef struct {
      logic                                 cmd;
      logic signed [rac_pkg::OPERAND_W-1:0] num;
      logic signed [rac_pkg::OPERAND_W-1:0] den;
      int unsigned                          idle;         // cycles waited before offering
      bit                                   drain_first;  // hold back until nothing is owed
   } fraction_req_type;

   typedef struct {
      logic signed [rac_pkg::RES_NUM_W-1:0] num;
      logic        [rac_pkg::RES_DEN_W-1:0] den;
      logic        [rac_pkg::STATUS_W-1:0]  status;
   } fraction_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rac_req_if req_chan ();
   rac_rsp_if rsp_chan ();

   rational_accumulator_normalize_top #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // pending requests, filled up front; responses still owed, oldest first
   fraction_req_type pending_reqs[$];
   fraction_rsp_type expected_sums[$];

   // model copy of the stored fraction
   longint acc_num = 0;
   longint acc_den = 1;

   int          req_taken   = 0;
   int          rsp_taken   = 0;
   int          mismatches  = 0;
   int          quiet_count = 0;
   int unsigned gap_left    = 0;
   bit          gap_armed   = 1'b0;
   int unsigned stall_left  = 0;
   logic        hold_rsp    = 1'b0;

   // -----------------------------------------------------------------------
   // Clock and reset
   // -----------------------------------------------------------------------
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // channel inputs known from time zero
   initial begin
      req_chan.valid       = 1'b0;
      req_chan.cmd         = CMD_LOAD;
      req_chan.operand_num = '0;
      req_chan.operand_den = '0;
      rsp_chan.ready       = 1'b0;
   end

   // -----------------------------------------------------------------------
   // Fraction model. A load is an add to 0/1. The sum a/b + c/d is formed
   // exactly in 64 bits, reduced by a Euclidean gcd, and the sign is moved
   // to the numerator. Zero denominator and out-of-range results leave the
   // stored value alone; the response always shows the stored value.
   // -----------------------------------------------------------------------
   function automatic fraction_rsp_type fold_request(
      logic cmd,
      logic signed [rac_pkg::OPERAND_W-1:0] c_in,
      logic signed [rac_pkg::OPERAND_W-1:0] d_in);
      longint           a, b, c, d, n, dn;
      logic [63:0]      mag, dmag, x, y, r, half;
      bit               neg;
      fraction_rsp_type rsp;
      begin
         half = 64'd1 << (VALUE_WIDTH - 1);
         a    = (cmd == CMD_ADD) ? acc_num : 0;
         b    = (cmd == CMD_ADD) ? acc_den : 1;
         c    = c_in;
         d    = d_in;
         rsp.status = rac_pkg::STATUS_OK;
         if (d == 0) begin
            rsp.status = rac_pkg::STATUS_ZERO_DEN;
         end else begin
            if (d < 0) begin
               c = -c;
               d = -d;
            end
            n  = a * d + c * b;
            dn = b * d;
            if (n == 0) begin
               acc_num = 0;
               acc_den = 1;
            end else begin
               neg  = (n < 0);
               mag  = neg ? -n : n;
               dmag = dn;
               x    = mag;
               y    = dmag;
               while (y != 0) begin
                  r = x % y;
                  x = y;
                  y = r;
               end
               mag  = mag / x;
               dmag = dmag / x;
               if (dmag > half - 1)
                  rsp.status = rac_pkg::STATUS_OVERFLOW;
               else if (neg ? (mag > half) : (mag > half - 1))
                  rsp.status = rac_pkg::STATUS_OVERFLOW;
               else begin
                  acc_num = neg ? -longint'(mag) : longint'(mag);
                  acc_den = longint'(dmag);
               end
            end
         end
         rsp.num = acc_num[rac_pkg::RES_NUM_W-1:0];
         rsp.den = acc_den[rac_pkg::RES_DEN_W-1:0];
         return rsp;
      end
   endfunction

   // -----------------------------------------------------------------------
   // Stimulus
   // -----------------------------------------------------------------------
   task automatic queue_request(logic cmd, logic signed [rac_pkg::OPERAND_W-1:0] num,
                                logic signed [rac_pkg::OPERAND_W-1:0] den,
                                int unsigned idle, bit drain_first);
      fraction_req_type req;
      begin
         req.cmd         = cmd;
         req.num         = num;
         req.den         = den;
         req.idle        = idle;
         req.drain_first = drain_first;
         pending_reqs.push_back(req);
      end
   endtask

   // mostly small values so sums stay in range, with full-width and edge values
   function automatic logic signed [rac_pkg::OPERAND_W-1:0] draw_operand();
      logic signed [rac_pkg::OPERAND_W-1:0] v;
      int unsigned                          sel;
      begin
         sel = $urandom_range(0, 9);
         v   = $urandom;
         case (sel)
            0, 1, 2, 3: v = int'($urandom_range(0, 40)) - 20;
            4:          v = v >>> 24;
            5:          v = v >>> 16;
            6, 7:       ;                        // full width
            8: begin
               case ($urandom_range(0, 4))
                  0:       v = OPND_MIN;
                  1:       v = OPND_MAX;
                  2:       v = OPND_MIN + 1;
                  3:       v = -1;
                  default: v = 1;
               endcase
            end
            default: begin
               v = 32'sd1 <<< $urandom_range(0, 31);
               if ($urandom_range(0, 1) != 0)
                  v = -v;
            end
         endcase
         return v;
      end
   endfunction

   // friendly divisors keep running sums alive for longer
   function automatic logic signed [rac_pkg::OPERAND_W-1:0] draw_denominator();
      logic signed [rac_pkg::OPERAND_W-1:0] v;
      begin
         if ($urandom_range(0, 9) < 6) begin
            v = int'($urandom_range(1, 12));
            if ($urandom_range(0, 3) == 0)
               v = -v;
         end else begin
            v = draw_operand();
         end
         return v;
      end
   endfunction

   initial begin
      int          total;
      int unsigned idle;
      logic        cmd;

      // directed corners: zero numerators, sign moves, zero denominators,
      // increment and decrement at the range limits, cancelling adds and
      // results that overflow the stored width
      queue_request(CMD_ADD,  0,         1,         0, 1'b0);
      queue_request(CMD_LOAD, 0,         -7,        0, 1'b0);
      queue_request(CMD_LOAD, 3,         6,         0, 1'b0);
      queue_request(CMD_ADD,  1,         3,         2, 1'b0);
      queue_request(CMD_ADD,  5,         0,         0, 1'b0);
      queue_request(CMD_LOAD, 9,         0,         0, 1'b0);
      queue_request(CMD_LOAD, 5,         -10,       1, 1'b0);
      queue_request(CMD_LOAD, 1,         3,         0, 1'b0);
      queue_request(CMD_ADD,  -1,        3,         0, 1'b0);
      queue_request(CMD_LOAD, OPND_MIN,  1,         3, 1'b0);
      queue_request(CMD_LOAD, OPND_MIN,  -1,        0, 1'b0);
      queue_request(CMD_LOAD, 1,         OPND_MIN,  0, 1'b0);
      queue_request(CMD_LOAD, -1,        OPND_MIN,  0, 1'b0);
      queue_request(CMD_LOAD, 2,         OPND_MIN,  0, 1'b0);
      queue_request(CMD_LOAD, OPND_MAX,  OPND_MIN,  0, 1'b0);
      queue_request(CMD_LOAD, OPND_MAX,  1,         0, 1'b0);
      queue_request(CMD_ADD,  1,         1,         0, 1'b0);
      queue_request(CMD_ADD,  -1,        1,         4, 1'b0);
      queue_request(CMD_LOAD, OPND_MAX,  OPND_MAX,  0, 1'b0);
      queue_request(CMD_LOAD, OPND_MIN,  OPND_MIN,  0, 1'b0);
      queue_request(CMD_LOAD, OPND_MIN,  OPND_MAX,  0, 1'b0);
      queue_request(CMD_LOAD, 1,         OPND_MAX,  0, 1'b0);
      queue_request(CMD_ADD,  1,         OPND_MAX - 1, 0, 1'b0);
      queue_request(CMD_LOAD, -1,        -1,        0, 1'b0);
      queue_request(CMD_ADD,  0,         0,         0, 1'b0);

      // random traffic: add runs broken up by loads, with stretches where
      // requests follow back to back and a few drain points
      for (int i = 0; i < RANDOM_REQS; i++) begin
         idle = ((i / 50) % 5 == 2) ? 0 : $urandom_range(0, MAX_IDLE);
         cmd  = ($urandom_range(0, 99) < 15) ? CMD_LOAD : CMD_ADD;
         queue_request(cmd, draw_operand(), draw_denominator(), idle,
                       (i % 350) == 175);
      end
      total = pending_reqs.size();

      while (req_taken < total) @(posedge clock);
      while (expected_sums.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_sums.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // -----------------------------------------------------------------------
   // Request driver. A request holds until taken; each one waits out its
   // own idle count first, and drain points wait until no response is owed.
   // The prediction is made on the edge that takes the request.
   // -----------------------------------------------------------------------
   always @(posedge clock) begin
      logic             taken;
      int unsigned      gap_v;
      bit               armed_v;
      fraction_req_type nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
         gap_left       <= 0;
         gap_armed      <= 1'b0;
      end else begin
         taken   = req_chan.valid && req_chan.ready;
         gap_v   = gap_left;
         armed_v = gap_armed;
         if (taken) begin
            expected_sums.push_back(fold_request(req_chan.cmd, req_chan.operand_num,
                                                 req_chan.operand_den));
            req_taken <= req_taken + 1;
         end
         if (!(req_chan.valid && !taken)) begin
            if (!armed_v && pending_reqs.size() > 0) begin
               gap_v   = pending_reqs[0].idle;
               armed_v = 1'b1;
            end
            if (gap_v > 0) begin
               gap_v          = gap_v - 1;
               req_chan.valid <= 1'b0;
            end else if (pending_reqs.size() > 0 &&
                         (!pending_reqs[0].drain_first || expected_sums.size() == 0)) begin
               nxt                  = pending_reqs.pop_front();
               armed_v              = 1'b0;
               req_chan.valid       <= 1'b1;
               req_chan.cmd         <= nxt.cmd;
               req_chan.operand_num <= nxt.num;
               req_chan.operand_den <= nxt.den;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
         gap_left  <= gap_v;
         gap_armed <= armed_v;
      end
   end

   // -----------------------------------------------------------------------
   // Response monitor. Stalls are drawn per response and only count down
   // while a response is waiting, so they really delay it; every fourth
   // block of 64 responses runs without stalls.
   // -----------------------------------------------------------------------
   always @(posedge clock) begin
      int unsigned      stall_v;
      fraction_rsp_type exp_rsp;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= 0;
      end else begin
         stall_v = stall_left;
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_taken <= rsp_taken + 1;
            if (expected_sums.size() == 0) begin
               if (mismatches < REPORT_LIMIT)
                  $display("unexpected response %0d/%0d status %0d", rsp_chan.result_num,
                           rsp_chan.result_den, rsp_chan.status);
               mismatches <= mismatches + 1;
            end else begin
               exp_rsp = expected_sums.pop_front();
               if (rsp_chan.result_num !== exp_rsp.num || rsp_chan.result_den !== exp_rsp.den ||
                   rsp_chan.status !== exp_rsp.status) begin
                  if (mismatches < REPORT_LIMIT)
                     $display("response %0d: expected %0d/%0d status %0d, got %0d/%0d status %0d",
                              rsp_taken, exp_rsp.num, exp_rsp.den, exp_rsp.status,
                              rsp_chan.result_num, rsp_chan.result_den, rsp_chan.status);
                  mismatches <= mismatches + 1;
               end
            end
            stall_v = ((rsp_taken / 64) % 4 == 1) ? 0 : $urandom_range(0, MAX_IDLE);
         end else if (rsp_chan.valid && stall_v > 0) begin
            stall_v = stall_v - 1;
         end
         stall_left     <= stall_v;
         rsp_chan.ready <= !hold_rsp && stall_v == 0;
      end
   end

   // one long back-pressure stretch mid-run: the sender keeps offering, so
   // the block fills its output register and sequencer and stops taking
   initial begin
      while (req_taken < HOLD_AFTER) @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // watchdog: too long without any handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_count <= 0;
      end else if (quiet_count >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_count <= quiet_count + 1;
      end
   end

endmodule

@@ filelist.f @@
rtl/rac_pkg.sv
rtl/rac_if.sv
rtl/rac_ctrl.sv
rtl/rac_datapath.sv
rtl/rational_accumulator_normalize_top.sv
tb/rational_accumulator_normalize_top_tb.sv
